[src/crmm_pkg.sv]
// ----------------------------------------------------------------------------
// Curve range min/max package
// Shared types, constants and the min/max merge function of the block.
// ----------------------------------------------------------------------------
package crmm_pkg;

    localparam int VAL_W     = 32;          // Q16.16 value width
    localparam int CFG_W     = 11;          // point count register width
    localparam int IDX_IN_W  = 10;          // point index field width
    localparam int EXT_W     = VAL_W + 1;   // difference of two values
    localparam int PROD_W    = 2 * EXT_W;   // exact interpolation product
    localparam int WIDE_W    = VAL_W + 3;   // interpolant before saturation
    localparam int DIV_CNT_W = 7;           // counts the PROD_W divider steps

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic                    command;
        logic [IDX_IN_W-1:0]     point_index;
        logic signed [VAL_W-1:0] x_value;
        logic signed [VAL_W-1:0] y_value;
        logic                    y_present;
        logic signed [VAL_W-1:0] x_low;
        logic signed [VAL_W-1:0] x_high;
    } t_in_item;

    typedef struct packed {
        logic                    found;
        logic signed [VAL_W-1:0] min_value;
        logic signed [VAL_W-1:0] max_value;
    } t_out_item;

    // A tree node, also used as the running min/max of a query.
    typedef struct packed {
        logic                    valid;
        logic signed [VAL_W-1:0] mn;
        logic signed [VAL_W-1:0] mx;
    } t_node;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_CLEAR,
        OP_TAKE,
        OP_LEAF,
        OP_UP_RD,
        OP_UP_WR,
        OP_S_RD,
        OP_SL_CMP,
        OP_SL_END,
        OP_SH_CMP,
        OP_PT_RD0,
        OP_PT_RD1,
        OP_PT_CAP1,
        OP_MUL,
        OP_DIV_START,
        OP_INTERP_FIN,
        OP_TQ_INIT,
        OP_TQ_RD,
        OP_TQ_FOLD,
        OP_RESULT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   hi_end;     // interpolation at the upper end of the range
    } t_dp_cmd;

    typedef struct packed {
        logic is_query;
        logic idx_bad;
        logic n_zero;
        logic par_root;
        logic ab_done;
        logic no_range;
        logic interp_ok;
        logic div_busy;
        logic tq_done;
        logic clr_last;
    } t_dp_status;

    // Merges node v into acc; an empty node leaves acc unchanged.
    function automatic t_node fold_node(input t_node acc, input t_node v);
        t_node res;
        res = acc;
        if (v.valid) begin
            if (!acc.valid) begin
                res = v;
            end else begin
                if (v.mn < acc.mn) res.mn = v.mn;
                if (v.mx > acc.mx) res.mx = v.mx;
            end
        end
        return res;
    endfunction

endpackage

[src/curve_range_min_max_core.sv]
// ----------------------------------------------------------------------------
// Curve range min/max core
// Stores curve points and answers min/max queries over x ranges.
// ----------------------------------------------------------------------------
// The input channel (i_in_valid / o_in_ready / i_in_data) carries one
// transaction per command. A load writes one point and updates the min/max
// tree from the leaf to the root, one tree level at a time on the tree
// memory's read and write ports; it produces no result. A query produces
// exactly one result transaction on the output channel (o_out_valid /
// i_out_ready / o_out_data). A query runs two binary searches on the point
// memory, fetches the end points, interpolates at the ends of the range
// where needed (one quotient bit per cycle in the serial divider) and then
// walks the tree. One transaction is worked on at a time. After reset a
// clearing pass empties the tree and the y-present flags; o_in_ready stays
// low until it ends, while the point count register (i_cfg_wr_en /
// i_cfg_wr_data) may already be written. After that the user must write the
// register only while no transaction is in flight; the block itself does
// not enforce it.
// The result sits in an output register, so the next transaction is taken
// while it waits; a stalled receiver only holds the block at the end of the
// following query.
// ----------------------------------------------------------------------------
module curve_range_min_max_core #(
    parameter int MAX_POINTS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  crmm_pkg::t_in_item            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output crmm_pkg::t_out_item           o_out_data,
    input  logic                          i_cfg_wr_en,
    input  logic [crmm_pkg::CFG_W-1:0]    i_cfg_wr_data
);

    crmm_pkg::t_dp_cmd    dp_cmd;
    crmm_pkg::t_dp_status dp_status;

    // The controller sequences every step; the datapath holds all values.
    crmm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    crmm_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .i_item        (i_in_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_out_data    (o_out_data)
    );

endmodule

[src/crmm_div.sv]
// ----------------------------------------------------------------------------
// Curve range min/max divider
// Restoring unsigned divider, one quotient bit per cycle, saturating result.
// ----------------------------------------------------------------------------
module crmm_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [crmm_pkg::PROD_W-1:0]   i_dividend,
    input  logic [crmm_pkg::EXT_W-1:0]    i_divisor,
    output logic                          o_busy,
    output logic [crmm_pkg::EXT_W-1:0]    o_quot
);

    localparam int PW = crmm_pkg::PROD_W;
    localparam int EW = crmm_pkg::EXT_W;
    localparam int VW = crmm_pkg::VAL_W;

    logic                             r_busy;
    logic [crmm_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [EW:0]                      r_rem;
    logic [PW-1:0]                    r_dvd;
    logic [PW-1:0]                    r_q;
    logic [EW-1:0]                    r_den;
    logic [EW:0]                      rem_sh;
    logic                             ge;
    logic [EW:0]                      n_rem;
    logic                             sat;

    always_comb begin
        rem_sh = {r_rem[EW-1:0], r_dvd[PW-1]};
        ge     = rem_sh >= {1'b0, r_den};
        n_rem  = ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
        // Quotients above 2^VAL_W all give the same saturated interpolant.
        sat    = (r_q[PW-1:EW] != '0) || (r_q[VW] && (r_q[VW-1:0] != '0));
        o_quot = sat ? {1'b1, {VW{1'b0}}} : r_q[EW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == crmm_pkg::DIV_CNT_W'(PW - 1)) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_den <= i_divisor;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[PW-2:0], 1'b0};
            r_q   <= {r_q[PW-2:0], ge};
        end
    end

    assign o_busy = r_busy;

endmodule

[src/crmm_dp.sv]
// ----------------------------------------------------------------------------
// Curve range min/max datapath
// Point and tree memories, search and tree pointers, interpolation, result.
// ----------------------------------------------------------------------------
module crmm_dp #(
    parameter int MAX_POINTS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  crmm_pkg::t_dp_cmd             i_cmd,
    output crmm_pkg::t_dp_status          o_status,
    input  crmm_pkg::t_in_item            i_item,
    input  logic                          i_cfg_wr_en,
    input  logic [crmm_pkg::CFG_W-1:0]    i_cfg_wr_data,
    output crmm_pkg::t_out_item           o_out_data
);

    localparam int NODES  = 2 * MAX_POINTS;
    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int NODE_W = $clog2(NODES);
    localparam int TR_W   = $clog2(NODES + 1);
    localparam int VW     = crmm_pkg::VAL_W;
    localparam int EW     = crmm_pkg::EXT_W;
    localparam int WW     = crmm_pkg::WIDE_W;

    typedef struct packed {
        logic                 pres;
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
    } t_point;

    t_point               mem_pt [MAX_POINTS];
    crmm_pkg::t_node      mem_tr [NODES];

    crmm_pkg::t_in_item   r_item;
    logic [CNT_W-1:0]     r_n;
    logic [CNT_W-1:0]     r_a;
    logic [CNT_W-1:0]     r_b;
    logic [CNT_W-1:0]     r_m;
    logic [CNT_W-1:0]     r_lo;
    logic [NODE_W-1:0]    r_p;
    logic [NODE_W-1:0]    r_clr;
    logic [TR_W-1:0]      r_l;
    logic [TR_W-1:0]      r_r;
    logic                 r_fl;
    logic                 r_fr;
    t_point               r_pt_rd;
    t_point               r_s0;
    t_point               r_s1;
    crmm_pkg::t_node      r_rd_a;
    crmm_pkg::t_node      r_rd_b;
    crmm_pkg::t_node      r_acc;
    logic                 r_neg;
    logic [crmm_pkg::PROD_W-1:0] r_prod;
    logic [EW-1:0]        r_den;
    crmm_pkg::t_out_item  r_out;

    logic [CNT_W:0]       ab_sum;
    logic [CNT_W-1:0]     mid;
    logic [IDX_W-1:0]     ld_idx;
    logic [NODE_W-1:0]    leaf;
    logic                 pt_we;
    logic [IDX_W-1:0]     pt_waddr;
    t_point               pt_wdata;
    logic [IDX_W-1:0]     pt_raddr;
    logic                 tr_we;
    logic [NODE_W-1:0]    tr_waddr;
    crmm_pkg::t_node      tr_wdata;
    logic [NODE_W-1:0]    tr_raddr_a;
    logic [NODE_W-1:0]    tr_raddr_b;
    logic [TR_W-1:0]      r_m1;
    logic signed [VW-1:0] xq;
    logic signed [EW-1:0] dt;
    logic signed [EW-1:0] dx;
    logic signed [EW-1:0] dy;
    logic [EW-1:0]        mag_t;
    logic [EW-1:0]        mag_x;
    logic [EW-1:0]        mag_y;
    logic                 div_busy;
    logic [EW-1:0]        quot;
    logic signed [WW-1:0] y0w;
    logic signed [WW-1:0] qw;
    logic signed [WW-1:0] iw;
    logic signed [VW-1:0] iv;
    logic                 ovf;
    logic                 ok_lo;
    logic                 ok_hi;
    crmm_pkg::t_node      tq_a;
    crmm_pkg::t_node      tq_b;
    crmm_pkg::t_node      iv_node;

    always_comb begin
        ab_sum   = (CNT_W + 1)'(r_a) + (CNT_W + 1)'(r_b);
        mid      = CNT_W'(ab_sum >> 1);
        ld_idx   = IDX_W'(r_item.point_index);
        leaf     = NODE_W'(ld_idx) + NODE_W'(MAX_POINTS);
        r_m1     = r_r - 1'b1;

        pt_we    = 1'b0;
        pt_waddr = IDX_W'(r_clr);
        pt_wdata = '0;
        if (i_cmd.op == crmm_pkg::OP_LEAF) begin
            pt_we    = 1'b1;
            pt_waddr = ld_idx;
            pt_wdata = '{pres: r_item.y_present, x: r_item.x_value, y: r_item.y_value};
        end else if (i_cmd.op == crmm_pkg::OP_CLEAR) begin
            pt_we = r_clr < NODE_W'(MAX_POINTS);
        end

        case (i_cmd.op)
            crmm_pkg::OP_S_RD:  pt_raddr = IDX_W'(mid);
            crmm_pkg::OP_PT_RD0: pt_raddr = i_cmd.hi_end ? IDX_W'(r_a - 1'b1)
                                                         : IDX_W'(r_lo - 1'b1);
            default:            pt_raddr = i_cmd.hi_end ? IDX_W'(r_a) : IDX_W'(r_lo);
        endcase

        tr_we    = 1'b0;
        tr_waddr = r_clr;
        tr_wdata = '0;
        case (i_cmd.op)
            crmm_pkg::OP_CLEAR: tr_we = 1'b1;
            crmm_pkg::OP_LEAF: begin
                tr_we    = 1'b1;
                tr_waddr = leaf;
                tr_wdata = '{valid: r_item.y_present, mn: r_item.y_value,
                             mx: r_item.y_value};
            end
            crmm_pkg::OP_UP_WR: begin
                tr_we    = 1'b1;
                tr_waddr = {1'b0, r_p[NODE_W-1:1]};
                tr_wdata = crmm_pkg::fold_node(r_rd_a, r_rd_b);
            end
            default: tr_we = 1'b0;
        endcase

        if (i_cmd.op == crmm_pkg::OP_UP_RD) begin
            tr_raddr_a = {r_p[NODE_W-1:1], 1'b0};
            tr_raddr_b = {r_p[NODE_W-1:1], 1'b1};
        end else begin
            tr_raddr_a = r_l[NODE_W-1:0];
            tr_raddr_b = r_m1[NODE_W-1:0];
        end

        // Interpolation between point s0 (left) and s1 (right).
        xq    = i_cmd.hi_end ? r_item.x_high : r_item.x_low;
        dt    = EW'(xq) - EW'(r_s0.x);
        dx    = EW'(r_s1.x) - EW'(r_s0.x);
        dy    = EW'(r_s1.y) - EW'(r_s0.y);
        mag_t = dt[EW-1] ? EW'(-dt) : EW'(dt);
        mag_x = dx[EW-1] ? EW'(-dx) : EW'(dx);
        mag_y = dy[EW-1] ? EW'(-dy) : EW'(dy);

        y0w = WW'(r_s0.y);
        qw  = $signed(WW'(quot));
        iw  = r_neg ? (y0w - qw) : (y0w + qw);
        ovf = (iw[WW-1:VW-1] != '0) && (iw[WW-1:VW-1] != '1);
        if (ovf) begin
            iv = iw[WW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
        end else begin
            iv = iw[VW-1:0];
        end
        iv_node = '{valid: 1'b1, mn: iv, mx: iv};

        ok_lo = (r_s1.x > r_item.x_low) && (r_lo != '0) && r_s0.pres && r_s1.pres
                && (r_s0.x != r_s1.x);
        ok_hi = (r_a < r_n) && (r_s0.x != r_item.x_high) && (r_s1.x > r_item.x_high)
                && r_s0.pres && r_s1.pres && (r_s0.x != r_s1.x);

        tq_a = r_fl ? r_rd_a : '0;
        tq_b = r_fr ? r_rd_b : '0;

        o_status.is_query  = r_item.command == crmm_pkg::CMD_QUERY;
        o_status.idx_bad   = 32'(r_item.point_index) >= 32'(MAX_POINTS);
        o_status.n_zero    = r_n == '0;
        o_status.par_root  = r_p[NODE_W-1:1] == (NODE_W - 1)'(1);
        o_status.ab_done   = r_a >= r_b;
        o_status.no_range  = (r_lo >= r_n) || (r_a == '0);
        o_status.interp_ok = i_cmd.hi_end ? ok_hi : ok_lo;
        o_status.div_busy  = div_busy;
        o_status.tq_done   = r_l >= r_r;
        o_status.clr_last  = r_clr == NODE_W'(NODES - 1);
    end

    always_ff @(posedge i_clk) begin
        if (pt_we) mem_pt[pt_waddr] <= pt_wdata;
        r_pt_rd <= mem_pt[pt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (tr_we) mem_tr[tr_waddr] <= tr_wdata;
        r_rd_a <= mem_tr[tr_raddr_a];
        r_rd_b <= mem_tr[tr_raddr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            r_n   <= '0;
        end else begin
            if (i_cmd.op == crmm_pkg::OP_CLEAR) r_clr <= r_clr + 1'b1;
            if (i_cfg_wr_en) begin
                if (32'(i_cfg_wr_data) > 32'(MAX_POINTS)) begin
                    r_n <= CNT_W'(MAX_POINTS);
                end else begin
                    r_n <= CNT_W'(i_cfg_wr_data);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            crmm_pkg::OP_TAKE: begin
                r_item      <= i_item;
                r_a         <= '0;
                r_b         <= r_n;
                r_acc.valid <= 1'b0;
            end
            crmm_pkg::OP_LEAF:   r_p <= leaf;
            crmm_pkg::OP_UP_WR:  r_p <= {1'b0, r_p[NODE_W-1:1]};
            crmm_pkg::OP_S_RD:   r_m <= mid;
            crmm_pkg::OP_SL_CMP: begin
                if (r_pt_rd.x < r_item.x_low) r_a <= r_m + 1'b1;
                else                          r_b <= r_m;
            end
            crmm_pkg::OP_SL_END: begin
                r_lo <= r_a;
                r_a  <= '0;
                r_b  <= r_n;
            end
            crmm_pkg::OP_SH_CMP: begin
                if (r_pt_rd.x <= r_item.x_high) r_a <= r_m + 1'b1;
                else                            r_b <= r_m;
            end
            crmm_pkg::OP_PT_RD1:  r_s0 <= r_pt_rd;
            crmm_pkg::OP_PT_CAP1: r_s1 <= r_pt_rd;
            crmm_pkg::OP_MUL: begin
                r_prod <= crmm_pkg::PROD_W'(mag_t) * crmm_pkg::PROD_W'(mag_y);
                r_den  <= mag_x;
                r_neg  <= dt[EW-1] ^ dx[EW-1] ^ dy[EW-1];
            end
            crmm_pkg::OP_INTERP_FIN: r_acc <= crmm_pkg::fold_node(r_acc, iv_node);
            crmm_pkg::OP_TQ_INIT: begin
                r_l <= TR_W'(r_lo) + TR_W'(MAX_POINTS);
                r_r <= TR_W'(r_a) + TR_W'(MAX_POINTS);
            end
            crmm_pkg::OP_TQ_RD: begin
                r_fl <= r_l[0];
                r_fr <= r_r[0];
            end
            crmm_pkg::OP_TQ_FOLD: begin
                r_acc <= crmm_pkg::fold_node(crmm_pkg::fold_node(r_acc, tq_a), tq_b);
                r_l   <= (r_l + TR_W'(r_fl)) >> 1;
                r_r   <= (r_r - TR_W'(r_fr)) >> 1;
            end
            crmm_pkg::OP_RESULT: begin
                if (r_acc.valid) begin
                    r_out <= '{found: 1'b1, min_value: r_acc.mn, max_value: r_acc.mx};
                end else begin
                    r_out <= '0;
                end
            end
            default: r_m <= r_m;
        endcase
    end

    crmm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.op == crmm_pkg::OP_DIV_START),
        .i_dividend (r_prod),
        .i_divisor  (r_den),
        .o_busy     (div_busy),
        .o_quot     (quot)
    );

    assign o_out_data = r_out;

endmodule

[src/crmm_ctrl.sv]
// ----------------------------------------------------------------------------
// Curve range min/max controller
// Sequences clearing, loads and queries and runs both handshakes.
// ----------------------------------------------------------------------------
module crmm_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    input  crmm_pkg::t_dp_status   i_status,
    output crmm_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DISPATCH, S_LEAF, S_UP_RD, S_UP_WR,
        S_SL_RD, S_SL_CMP, S_SH_RD, S_SH_CMP, S_RANGE,
        S_PT_RD0, S_PT_RD1, S_PT_CAP, S_PT_CHK, S_DIV_GO, S_DIV_WAIT,
        S_TQ_INIT, S_TQ_RD, S_TQ_FOLD, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready;
    logic   r_out_valid, n_out_valid;
    logic   r_hi_end, n_hi_end;
    logic   end_next;

    always_comb begin
        n_state     = r_state;
        n_hi_end    = r_hi_end;
        o_cmd.op    = crmm_pkg::OP_NOP;
        o_cmd.hi_end = r_hi_end;
        end_next    = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;

        case (r_state)
            S_CLEAR: begin
                o_cmd.op = crmm_pkg::OP_CLEAR;
                if (i_status.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid && r_in_ready) begin
                    o_cmd.op = crmm_pkg::OP_TAKE;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (!i_status.is_query) n_state = i_status.idx_bad ? S_IDLE : S_LEAF;
                else                    n_state = i_status.n_zero ? S_DONE : S_SL_RD;
            end
            S_LEAF: begin
                o_cmd.op = crmm_pkg::OP_LEAF;
                n_state  = S_UP_RD;
            end
            S_UP_RD: begin
                o_cmd.op = crmm_pkg::OP_UP_RD;
                n_state  = S_UP_WR;
            end
            S_UP_WR: begin
                o_cmd.op = crmm_pkg::OP_UP_WR;
                n_state  = i_status.par_root ? S_IDLE : S_UP_RD;
            end
            S_SL_RD: begin
                if (i_status.ab_done) begin
                    o_cmd.op = crmm_pkg::OP_SL_END;
                    n_state  = S_SH_RD;
                end else begin
                    o_cmd.op = crmm_pkg::OP_S_RD;
                    n_state  = S_SL_CMP;
                end
            end
            S_SL_CMP: begin
                o_cmd.op = crmm_pkg::OP_SL_CMP;
                n_state  = S_SL_RD;
            end
            S_SH_RD: begin
                if (i_status.ab_done) begin
                    n_state = S_RANGE;
                end else begin
                    o_cmd.op = crmm_pkg::OP_S_RD;
                    n_state  = S_SH_CMP;
                end
            end
            S_SH_CMP: begin
                o_cmd.op = crmm_pkg::OP_SH_CMP;
                n_state  = S_SH_RD;
            end
            S_RANGE: begin
                n_hi_end = 1'b0;
                n_state  = i_status.no_range ? S_DONE : S_PT_RD0;
            end
            S_PT_RD0: begin
                o_cmd.op = crmm_pkg::OP_PT_RD0;
                n_state  = S_PT_RD1;
            end
            S_PT_RD1: begin
                o_cmd.op = crmm_pkg::OP_PT_RD1;
                n_state  = S_PT_CAP;
            end
            S_PT_CAP: begin
                o_cmd.op = crmm_pkg::OP_PT_CAP1;
                n_state  = S_PT_CHK;
            end
            S_PT_CHK: begin
                if (i_status.interp_ok) begin
                    o_cmd.op = crmm_pkg::OP_MUL;
                    n_state  = S_DIV_GO;
                end else begin
                    end_next = 1'b1;
                end
            end
            S_DIV_GO: begin
                o_cmd.op = crmm_pkg::OP_DIV_START;
                n_state  = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (!i_status.div_busy) begin
                    o_cmd.op = crmm_pkg::OP_INTERP_FIN;
                    end_next = 1'b1;
                end
            end
            S_TQ_INIT: begin
                o_cmd.op = crmm_pkg::OP_TQ_INIT;
                n_state  = S_TQ_RD;
            end
            S_TQ_RD: begin
                if (i_status.tq_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = crmm_pkg::OP_TQ_RD;
                    n_state  = S_TQ_FOLD;
                end
            end
            S_TQ_FOLD: begin
                o_cmd.op = crmm_pkg::OP_TQ_FOLD;
                n_state  = S_TQ_RD;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = crmm_pkg::OP_RESULT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // The lower end is followed by the upper end, then the tree walk.
        if (end_next) begin
            if (r_hi_end) begin
                n_state = S_TQ_INIT;
            end else begin
                n_hi_end = 1'b1;
                n_state  = S_PT_RD0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_in_ready  <= 1'b0;
            r_out_valid <= 1'b0;
            r_hi_end    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_ready  <= n_state == S_IDLE;
            r_out_valid <= n_out_valid;
            r_hi_end    <= n_hi_end;
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

endmodule

[src/crmm_checker.sv]
// ----------------------------------------------------------------------------
// Curve range min/max checker
// Port-level assertions on the core, attached by a bind statement.
// ----------------------------------------------------------------------------
module crmm_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input crmm_pkg::t_out_item   o_out_data
);

    // A stalled result must stay on the port unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed or dropped while stalled");

    // The clearing pass follows reset, so nothing is accepted just after it.
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("input ready straight after reset");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.found |->
            o_out_data.min_value == '0 && o_out_data.max_value == '0)
        else $error("not-found result with non-zero values");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.found |->
            o_out_data.min_value <= o_out_data.max_value)
        else $error("minimum above maximum");

endmodule

bind curve_range_min_max_core crmm_checker u_crmm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

[dv/curve_range_min_max_core_test.sv]
// ----------------------------------------------------------------------------
// Curve range min/max core testbench
// Loads curves of increasing x, reprograms the point count and runs range
// queries. Every result is checked against an in-bench segment tree model.
// ----------------------------------------------------------------------------
module curve_range_min_max_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  NPTS   = 1024;
    localparam int  NNODES = 2 * NPTS - 1;
    localparam longint VMAX = 64'sd2147483647;
    localparam longint VMIN = -64'sd2147483648;

    // Scoreboard: holds its own copy of the point store, the min/max tree and
    // the point count, and queues the answer that each query should produce.
    class curve_scoreboard;
        longint    xs[NPTS];
        longint    ys[NPTS];
        bit        pres[NPTS];
        bit        nvalid[NNODES];
        longint    nmin[NNODES];
        longint    nmax[NNODES];
        int unsigned npoints;
        crmm_pkg::t_out_item answers[$];
        int        errors;

        function void set_count(int unsigned v);
            npoints = (v > NPTS) ? NPTS : v;
        endfunction

        function int pending();
            return answers.size();
        endfunction

        function void merge(inout bit ok, inout longint mn, inout longint mx,
                            input bit vok, input longint vmn, input longint vmx);
            if (!vok) return;
            if (!ok) begin
                ok = 1'b1;
                mn = vmn;
                mx = vmx;
            end else begin
                if (vmn < mn) mn = vmn;
                if (vmx > mx) mx = vmx;
            end
        endfunction

        // Product is exact at 80 bits; the division truncates toward zero.
        function longint interp(longint xq, longint x0, longint x1,
                                longint y0, longint y1);
            logic signed [79:0] t, d, dy, q, w;
            t  = xq - x0;
            d  = x1 - x0;
            dy = y1 - y0;
            q  = (t * dy) / d;
            w  = q + y0;
            if (w > VMAX) return VMAX;
            if (w < VMIN) return VMIN;
            return longint'(w);
        endfunction

        function void note_input(crmm_pkg::t_in_item it);
            int unsigned idx, leaf, p, par, a, b, m, lo, hi, l, r;
            bit     ok;
            longint mn, mx, xl, xh, v;
            crmm_pkg::t_out_item res;
            if (it.command == crmm_pkg::CMD_LOAD) begin
                idx       = it.point_index;
                xs[idx]   = longint'(it.x_value);
                ys[idx]   = longint'(it.y_value);
                pres[idx] = it.y_present;
                leaf      = idx + NPTS - 1;
                nvalid[leaf] = it.y_present;
                nmin[leaf]   = it.y_present ? ys[idx] : 0;
                nmax[leaf]   = it.y_present ? ys[idx] : 0;
                // Recompute every ancestor of the leaf up to the root.
                p = leaf + 1;
                while (p > 1) begin
                    par = p >> 1;
                    ok = 0; mn = 0; mx = 0;
                    merge(ok, mn, mx, nvalid[2*par-1], nmin[2*par-1], nmax[2*par-1]);
                    merge(ok, mn, mx, nvalid[2*par], nmin[2*par], nmax[2*par]);
                    nvalid[par-1] = ok;
                    nmin[par-1]   = ok ? mn : 0;
                    nmax[par-1]   = ok ? mx : 0;
                    p = par;
                end
                return;
            end
            res = '0;
            ok = 0; mn = 0; mx = 0;
            xl = longint'(it.x_low);
            xh = longint'(it.x_high);
            if (npoints == 0) begin
                answers.push_back(res);
                return;
            end
            a = 0; b = npoints;
            while (a < b) begin
                m = (a + b) >> 1;
                if (xs[m] < xl) a = m + 1; else b = m;
            end
            lo = a;
            a = 0; b = npoints;
            while (a < b) begin
                m = (a + b) >> 1;
                if (xs[m] <= xh) a = m + 1; else b = m;
            end
            if (lo >= npoints || a == 0) begin
                answers.push_back(res);
                return;
            end
            hi = a - 1;
            if (xs[lo] > xl && lo > 0 && pres[lo] && pres[lo-1] && xs[lo-1] != xs[lo]) begin
                v = interp(xl, xs[lo-1], xs[lo], ys[lo-1], ys[lo]);
                merge(ok, mn, mx, 1'b1, v, v);
            end
            if (hi + 1 < npoints && xs[hi] != xh && xs[hi+1] > xh && pres[hi]
                && pres[hi+1] && xs[hi+1] != xs[hi]) begin
                v = interp(xh, xs[hi], xs[hi+1], ys[hi], ys[hi+1]);
                merge(ok, mn, mx, 1'b1, v, v);
            end
            if (hi >= lo) begin
                l = lo + NPTS;
                r = hi + NPTS + 1;
                while (l < r) begin
                    if (l & 1) begin
                        merge(ok, mn, mx, nvalid[l-1], nmin[l-1], nmax[l-1]);
                        l++;
                    end
                    if (r & 1) begin
                        r--;
                        merge(ok, mn, mx, nvalid[r-1], nmin[r-1], nmax[r-1]);
                    end
                    l >>= 1;
                    r >>= 1;
                end
            end
            if (ok) begin
                res.found     = 1'b1;
                res.min_value = mn[31:0];
                res.max_value = mx[31:0];
            end
            answers.push_back(res);
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(crmm_pkg::t_out_item got);
            crmm_pkg::t_out_item want;
            if (answers.size() == 0) begin
                report("result transaction with no query outstanding");
                return;
            end
            want = answers.pop_front();
            if (got.found !== want.found)
                report($sformatf("found got %0b want %0b", got.found, want.found));
            if (got.min_value !== want.min_value)
                report($sformatf("min_value got %0d want %0d",
                                 got.min_value, want.min_value));
            if (got.max_value !== want.max_value)
                report($sformatf("max_value got %0d want %0d",
                                 got.max_value, want.max_value));
        endtask
    endclass

    logic                         i_clk;
    logic                         i_rst_n       = 1'b0;
    logic                         in_valid      = 1'b0;
    logic                         in_ready;
    crmm_pkg::t_in_item           in_data       = '0;
    logic                         out_valid;
    logic                         out_ready     = 1'b0;
    crmm_pkg::t_out_item          out_data;
    logic                         cfg_wr_en     = 1'b0;
    logic [crmm_pkg::CFG_W-1:0]   cfg_wr_data   = '0;

    curve_scoreboard sb = new();

    // Idling controls, changed from phase to phase by the stimulus.
    int     send_idle   = 0;      // chance in a hundred of an idle sender cycle
    int     recv_stall  = 0;      // chance in a hundred of a stalled receiver cycle
    int     hold_cycles = 0;      // long receiver hold-off, counted down below
    int     items       = 0;
    longint step_max    = 1;      // largest x spacing of the current curve

    curve_range_min_max_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_in_data     (in_data),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_out_data    (out_data),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: check each accepted transaction against the oldest answer,
    // then decide whether to accept in the next cycle. While a hold-off is
    // running the receiver refuses everything, so the block fills up.
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready)
            sb.check_result(out_data);
        if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // Every field gets random bits, including those the command ignores.
    function automatic crmm_pkg::t_in_item random_item();
        crmm_pkg::t_in_item it;
        it.command     = 1'($urandom_range(1));
        it.point_index = crmm_pkg::IDX_IN_W'($urandom);
        it.x_value     = $urandom;
        it.y_value     = $urandom;
        it.y_present   = 1'($urandom_range(1));
        it.x_low       = $urandom;
        it.x_high      = $urandom;
        return it;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > VMAX) return VMAX;
        if (v < VMIN) return VMIN;
        return v;
    endfunction

    // Here valid is only lowered when an idle gap is taken, so a transaction that
    // follows straight on keeps valid high without a second assignment.
    task automatic send(crmm_pkg::t_in_item it);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (!in_ready);
        sb.note_input(it);
        items++;
    endtask

    task automatic load_point(int idx, longint x, longint y, bit p);
        crmm_pkg::t_in_item it;
        it             = random_item();
        it.command     = crmm_pkg::CMD_LOAD;
        it.point_index = crmm_pkg::IDX_IN_W'(idx);
        it.x_value     = x[31:0];
        it.y_value     = y[31:0];
        it.y_present   = p;
        send(it);
    endtask

    task automatic query(longint xl, longint xh);
        crmm_pkg::t_in_item it;
        it         = random_item();
        it.command = crmm_pkg::CMD_QUERY;
        it.x_low   = xl[31:0];
        it.x_high  = xh[31:0];
        send(it);
    endtask

    // Waits until every answer is back, then long enough for a trailing load
    // to walk the tree, so that the block is idle.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_count(int unsigned v);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= crmm_pkg::CFG_W'(v);
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
        sb.set_count(v);
    endtask

    function automatic longint random_y();
        case ($urandom_range(3))
            0:       return longint'(int'($urandom));
            1:       return VMAX - $urandom_range(3);
            2:       return VMIN + $urandom_range(3);
            default: return longint'($urandom_range(2 << 20)) - (1 << 20);
        endcase
    endfunction

    // Loads points 0 to n-1, with strictly increasing x unless asked not to.
    task automatic build_curve(int n, bit ordered);
        longint x;
        step_max = 64'd4294967295 / (n + 2);
        x = VMIN + $urandom_range(0, int'(step_max));
        for (int i = 0; i < n; i++) begin
            if (ordered)
                x = x + $urandom_range(1, int'(step_max));
            else
                x = longint'(int'($urandom));
            load_point(i, x, random_y(), $urandom_range(99) < 80);
        end
    endtask

    // An x near a stored point: exactly on it, or a little either side.
    function automatic longint near_x(int n);
        int i;
        i = $urandom_range(0, n - 1);
        case ($urandom_range(2))
            0:       return sb.xs[i];
            1:       return clamp32(sb.xs[i] + $urandom_range(0, int'(step_max)));
            default: return clamp32(sb.xs[i] - $urandom_range(0, int'(step_max)));
        endcase
    endfunction

    // Mostly well-formed queries; some reloads, loads beyond the count and
    // queries with arbitrary bounds mixed in.
    task automatic mixed_traffic(int n, int count);
        int sel, idx;
        longint a, b;
        for (int k = 0; k < count; k++) begin
            sel = $urandom_range(99);
            if (sel < 70) begin
                a = near_x(n);
                b = near_x(n);
                if (a > b && $urandom_range(3) != 0) query(b, a);
                else query(a, b);
            end else if (sel < 80) begin
                // Same x keeps the curve ordered; only y and presence change.
                idx = $urandom_range(0, n - 1);
                load_point(idx, sb.xs[idx], random_y(), 1'($urandom_range(1)));
            end else if (sel < 88) begin
                if (n < NPTS)
                    load_point($urandom_range(n, NPTS - 1), longint'(int'($urandom)),
                               longint'(int'($urandom)), 1'($urandom_range(1)));
                else
                    query(VMIN, VMAX);
            end else begin
                query(longint'(int'($urandom)), longint'(int'($urandom)));
            end
        end
    endtask

    initial begin
        int n;
        int phase;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. An empty curve first, accepted once the clearing
        // pass after reset has finished.
        write_count(0);
        query(VMIN, VMAX);
        // Four points spanning the whole x range, with y at both extremes and
        // one gap; a load beyond the count as well.
        load_point(0, VMIN, VMAX, 1'b1);
        load_point(1, 64'sd65536, VMIN, 1'b1);
        load_point(2, 64'sd131072, 5, 1'b0);
        load_point(3, VMAX, -7, 1'b1);
        load_point(NPTS - 1, 12345, 678, 1'b1);
        write_count(4);
        query(VMIN, VMAX);                  // whole curve
        query(64'sd65536, 64'sd65536);      // exactly on a point
        query(-64'sd1000, 64'sd65536);      // lower end interpolated
        query(VMIN, 64'sd1000);             // upper end interpolated
        query(64'sd70000, 64'sd100000);     // inside a gap, nothing found
        query(64'sd70000, 64'sd200000);     // gap beside the lower end
        query(64'sd65536, VMIN);            // inverted range
        query(VMAX, VMAX);                  // last point only
        query(-64'sd5, -64'sd2);            // both ends between two points
        write_count(1);
        query(VMIN, VMAX);                  // single point
        query(64'sd1, VMAX);                // beyond the only point
        write_count(2);
        query(-64'sd1000, VMAX);

        // Random phases, each with its own curve, count and idling pattern.
        phase = 0;
        while (items < 1100) begin
            case (phase % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 88; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 88; end
                default: begin send_idle = 18; recv_stall = 18; end
            endcase
            if (phase == 3) begin
                // Full-size curve, then a count above the maximum.
                build_curve(NPTS, 1'b1);
                write_count(NPTS);
                mixed_traffic(NPTS, 30);
                write_count(2047);
                mixed_traffic(NPTS, 30);
            end else begin
                n = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
                build_curve(n, (phase % 5) != 4);
                write_count(n);
                // Long hold-off on the result side while queries keep coming.
                if (phase == 1)
                    hold_cycles = 3000;
                mixed_traffic(n, 40);
            end
            phase++;
        end

        settle();
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #50ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule

[sim.f]
src/crmm_pkg.sv
src/crmm_div.sv
src/crmm_dp.sv
src/crmm_ctrl.sv
src/curve_range_min_max_core.sv
src/crmm_checker.sv
dv/curve_range_min_max_core_test.sv
